>>> rtl/sorted_table_binary_search_assert.svh
// ----------------------------------------------------------------------------
// Sorted-table binary search: assertion macros
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// Plain property, checked every cycle outside reset.
`define STBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted-table binary search: package
// Field widths, command codes, FSM states and controller/datapath bundles.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  // fixed request/response field widths
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 8;

  // request command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_EMIT
  } stbs_state_e;

  typedef struct packed {
    logic write;      // store one table entry
    logic start;      // load interval and key, issue first read
    logic step;       // narrow interval, issue next read
    logic mark_hit;
    logic mark_miss;
    logic emit;       // load output register
  } stbs_cmd_t;

  typedef struct packed {
    logic empty;      // saturated count is zero
    logic hit;        // probe equals key
    logic go_left;    // probe greater than key
    logic left_ok;    // left half not empty
    logic right_ok;   // right half not empty
    logic out_free;   // output register can take a result
  } stbs_status_t;

endpackage

>>> rtl/stbs_if.sv
// ----------------------------------------------------------------------------
// Sorted-table binary search: channel interfaces
// Valid/ready request, response and configuration channels.
// ----------------------------------------------------------------------------
interface stbs_req_if import stbs_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [INDEX_W-1:0]        entry_index;
  logic signed [DATA_W-1:0]  data_value;

  modport source (output valid, cmd, entry_index, data_value, input ready);
  modport sink   (input valid, cmd, entry_index, data_value, output ready);
endinterface

interface stbs_rsp_if import stbs_pkg::*;;
  logic               valid;
  logic               ready;
  logic               found;
  logic [POS_W-1:0]   position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

interface stbs_cfg_if import stbs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CFG_W-1:0]   entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink   (input valid, entries_in_use, output ready);
endinterface

>>> rtl/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// Sorted-table binary search: top level
// Table of signed entries with binary search over the leading entries.
// ----------------------------------------------------------------------------
// A write request (cmd = write) stores data_value at entry_index and returns
// nothing; indexes at or beyond TABLE_DEPTH are dropped. A search request
// (cmd = search) looks for data_value among the first entries_in_use
// entries (clamped to TABLE_DEPTH), which must be written beforehand and
// are expected to be sorted ascending as signed numbers. It returns one
// response: found and the matching position, or found = 0 and position 0.
// A write stores its entry on acceptance and the block stays idle. A search
// launches the first table read, then probes, then loads the output
// register. The table RAM has one read port with registered data, so the
// search loop does one probe per cycle; probes are at most floor(log2(n)) + 1
// for n live entries. An empty table skips the probes and answers with a
// miss. The block takes one request at a time; a finished response sits in
// the output register while the next request is accepted, and a search
// stalls only at its end if that register is still full. entries_in_use may
// be written at any time the block is quiet; its port is always ready. There
// is no clearing pass after reset: the table content is undefined until
// written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stbs_req_if.sink    req,
  stbs_cfg_if.sink    cfg,
  stbs_rsp_if.source  rsp
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] entries_in_use_q, entries_in_use_d;
  logic [EXT_W-1:0] count_ext;
  logic [CNT_W-1:0] count_sat;
  stbs_cmd_t        cmd;
  stbs_status_t     status;

  // configuration register, always ready
  assign cfg.ready        = 1'b1;
  assign entries_in_use_d = (cfg.valid && cfg.ready) ? cfg.entries_in_use : entries_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_in_use_q <= '0;
    end else begin
      entries_in_use_q <= entries_in_use_d;
    end
  end

  // clamp the live count to the table depth
  assign count_ext = EXT_W'(entries_in_use_q);
  assign count_sat = (count_ext > EXT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(count_ext);

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_cmd_i   (req.cmd),
    .req_ready_o (req.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .count_i        (count_sat),
    .entry_index_i  (req.entry_index),
    .data_value_i   (req.data_value),
    .rsp_ready_i    (rsp.ready),
    .rsp_valid_o    (rsp.valid),
    .rsp_found_o    (rsp.found),
    .rsp_position_o (rsp.position)
  );

endmodule

>>> rtl/stbs_ram.sv
// ----------------------------------------------------------------------------
// Sorted-table binary search: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted-table binary search: controller
// Sequences writes, probe iterations and result hand-off.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_assert.svh"

module stbs_ctrl import stbs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  input  logic         req_cmd_i,
  output logic         req_ready_o,
  input  stbs_status_t status_i,
  output stbs_cmd_t    cmd_o
);

  stbs_state_e state_q, state_d;
  logic        accept;
  logic        go_on;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  // another probe exists on the chosen side
  assign go_on       = status_i.go_left ? status_i.left_ok : status_i.right_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (req_cmd_i == CMD_SEARCH)) begin
          state_d = status_i.empty ? S_EMIT : S_PROBE;
        end
      end
      S_PROBE: begin
        if (status_i.hit || !go_on) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_cmd_i == CMD_WRITE) begin
            cmd_o.write = 1'b1;
          end else if (status_i.empty) begin
            cmd_o.mark_miss = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (status_i.hit) begin
          cmd_o.mark_hit = 1'b1;
        end else if (go_on) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.mark_miss = 1'b1;
        end
      end
      S_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  `STBS_ASSERT_NEXT(a_search_leaves_idle, accept && (req_cmd_i == CMD_SEARCH), state_q != S_IDLE, "search request did not start a search")
  `STBS_ASSERT_NEXT(a_write_stays_idle, accept && (req_cmd_i == CMD_WRITE), state_q == S_IDLE, "write request left idle")
  `STBS_ASSERT(a_single_command, $onehot0(cmd_o), "more than one datapath command")

endmodule

>>> rtl/stbs_datapath.sv
// ----------------------------------------------------------------------------
// Sorted-table binary search: datapath
// Table RAM, search interval, probe compare and output register.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_assert.svh"

module stbs_datapath import stbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH),
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  stbs_cmd_t                cmd_i,
  output stbs_status_t             status_o,
  input  logic [CNT_W-1:0]         count_i,
  input  logic [INDEX_W-1:0]       entry_index_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  logic                     rsp_ready_i,
  output logic                     rsp_valid_o,
  output logic                     rsp_found_o,
  output logic [POS_W-1:0]         rsp_position_o
);

  localparam int unsigned WIDX_W = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

  logic [CNT_W-1:0]              lo_q, lo_d, hi_q, hi_d, mid_p1;
  logic [ADDR_W-1:0]             mid_q, mid_d, mid_start, mid_left, mid_right;
  logic [ADDR_W-1:0]             rd_addr, wr_addr;
  logic [CNT_W:0]                sum_left, sum_right;
  logic signed [VALUE_WIDTH-1:0] key_q, key_d, value_ext, probe;
  logic [WIDX_W-1:0]             widx;
  logic                          in_range;
  logic                          found_q, found_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_found_q, out_found_d;
  logic [POS_W-1:0]              out_pos_q, out_pos_d;

  // sign-extend or truncate the 32-bit field to the table width
  assign value_ext = VALUE_WIDTH'(data_value_i);

  assign widx     = WIDX_W'(entry_index_i);
  assign wr_addr  = widx[ADDR_W-1:0];
  assign in_range = ((WIDX_W + 1)'(entry_index_i) < (WIDX_W + 1)'(TABLE_DEPTH));

  // candidate midpoints for both halves, ready before the compare resolves
  assign mid_start = ADDR_W'(count_i >> 1);
  assign mid_p1    = CNT_W'(mid_q) + CNT_W'(1);
  assign sum_left  = (CNT_W + 1)'(lo_q) + (CNT_W + 1)'(mid_q);
  assign sum_right = (CNT_W + 1)'(mid_p1) + (CNT_W + 1)'(hi_q);
  assign mid_left  = ADDR_W'(sum_left >> 1);
  assign mid_right = ADDR_W'(sum_right >> 1);

  stbs_ram #(
    .Width (VALUE_WIDTH),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write && in_range),
    .waddr_i (wr_addr),
    .wdata_i (value_ext),
    .raddr_i (rd_addr),
    .rdata_o (probe)
  );

  assign status_o.empty    = (count_i == '0);
  assign status_o.hit      = (probe == key_q);
  assign status_o.go_left  = (probe > key_q);
  assign status_o.left_ok  = (lo_q < CNT_W'(mid_q));
  assign status_o.right_ok = (mid_p1 < hi_q);
  assign status_o.out_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    priority if (cmd_i.start) begin
      rd_addr = mid_start;
    end else if (cmd_i.step) begin
      rd_addr = status_o.go_left ? mid_left : mid_right;
    end else begin
      rd_addr = mid_q;
    end
  end

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    key_d   = key_q;
    found_d = found_q;
    if (cmd_i.start) begin
      lo_d  = '0;
      hi_d  = count_i;
      mid_d = mid_start;
      key_d = value_ext;
    end
    if (cmd_i.step) begin
      if (status_o.go_left) begin
        hi_d  = CNT_W'(mid_q);
        mid_d = mid_left;
      end else begin
        lo_d  = mid_p1;
        mid_d = mid_right;
      end
    end
    if (cmd_i.mark_hit) begin
      found_d = 1'b1;
    end
    if (cmd_i.mark_miss) begin
      found_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_found_d = found_q;
      out_pos_d   = found_q ? POS_W'(mid_q) : '0;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q       <= mid_d;
    key_q       <= key_d;
    found_q     <= found_d;
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
  end

  assign rsp_valid_o    = out_valid_q;
  assign rsp_found_o    = out_found_q;
  assign rsp_position_o = out_pos_q;

  `STBS_ASSERT_NEXT(a_mid_in_interval, cmd_i.start || cmd_i.step, (lo_q <= CNT_W'(mid_q)) && (CNT_W'(mid_q) < hi_q), "probe outside live interval")
  `STBS_ASSERT_NEXT(a_emit_loads_output, cmd_i.emit, out_valid_q, "result not registered")
  `STBS_ASSERT(a_miss_zero_position, !(out_valid_q && !out_found_q) || (out_pos_q == '0), "miss carries nonzero position")

endmodule
